// File: src/rpr_pkg.sv
// Shared types, field widths and codes for the rotary pair rotator.
// No dependencies; every other file but rpr_queue imports this package.
package rpr_pkg;

  // Fixed field widths
  localparam int MODE_W      = 2;
  localparam int POS_W       = 9;
  localparam int PAIR_W      = 6;
  localparam int STATUS_W    = 2;
  localparam int PAIRS_CFG_W = 7;
  localparam int POSNS_CFG_W = 10;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int TABLE_W     = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Q.26 -> Q.12 rounding
  localparam int ROUND_SHIFT = 14;

  localparam logic [PAIRS_CFG_W-1:0] PAIRS_RESET = 7'd64;
  localparam logic [POSNS_CFG_W-1:0] POSNS_RESET = 10'd512;

  localparam logic signed [TABLE_W-1:0] Q14_ONE = 16'sd16384;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_INV  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_LOAD = 2'd1,
    OP_FWD  = 2'd2,
    OP_INV  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_POS_RANGE  = 2'd1,
    ST_PAIR_RANGE = 2'd2,
    ST_SAT        = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAIRS_IN_USE     = 1'b0,
    REG_POSITIONS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PAIRS_CFG_W-1:0] pairs_in_use;
    logic [POSNS_CFG_W-1:0] positions_in_use;
  } cfg_t;

  typedef struct packed {
    op_e     op;
    status_e status;
  } ctrl_t;

  // Clamp a Q1.14 table value to plus or minus one
  function automatic logic signed [TABLE_W-1:0] clamp_q14(input logic signed [TABLE_W-1:0] v);
    logic signed [TABLE_W-1:0] r;
    if (v > Q14_ONE) begin
      r = Q14_ONE;
    end else if (v < -Q14_ONE) begin
      r = -Q14_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: src/rpr_if.sv
// Valid/ready stream interfaces for input items and result items.
// Depends on rpr_pkg for field widths.
interface rpr_in_if #(
  parameter int DATA_WIDTH = 16
);
  import rpr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [MODE_W-1:0]            mode;
  logic [POS_W-1:0]             position;
  logic [PAIR_W-1:0]            pair_index;
  logic signed [DATA_WIDTH-1:0] value_even;
  logic signed [DATA_WIDTH-1:0] value_odd;

  modport source (output valid, mode, position, pair_index, value_even, value_odd,
                  input ready);
  modport sink   (input valid, mode, position, pair_index, value_even, value_odd,
                  output ready);
endinterface

interface rpr_out_if #(
  parameter int DATA_WIDTH = 16
);
  import rpr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_even;
  logic signed [DATA_WIDTH-1:0] out_odd;
  logic [STATUS_W-1:0]          status;

  modport source (output valid, out_even, out_odd, status, input ready);
  modport sink   (input valid, out_even, out_odd, status, output ready);
endinterface

// File: src/rpr_queue.sv
// Small FIFO that decouples the classifying front from the arithmetic back.
// Generic payload; no package dependency beyond the shared build order.
module rpr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/rpr_front.sv
// Front end: accepts input items, range-checks them, computes the table
// address and clamps load values. Depends on rpr_pkg and rpr_in_if.
module rpr_front #(
  parameter int MAX_POSITIONS = 512,
  parameter int MAX_PAIRS     = 64,
  parameter int DATA_WIDTH    = 16,
  parameter int ADDR_W        = 15,
  parameter int VAL_W         = 16
) (
  rpr_in_if.sink                 in_ch,
  input  rpr_pkg::cfg_t          cfg_i,
  input  logic                   queue_ready_i,
  output logic                   push_o,
  output rpr_pkg::ctrl_t         ctrl_o,
  output logic [ADDR_W-1:0]      addr_o,
  output logic signed [VAL_W-1:0] a_o,
  output logic signed [VAL_W-1:0] b_o
);
  import rpr_pkg::*;

  logic                        pos_bad, pair_bad;
  op_e                         op_sel;
  logic signed [TABLE_W-1:0]   cos_raw, sin_raw;

  assign in_ch.ready = queue_ready_i;
  assign push_o      = in_ch.valid && queue_ready_i;

  assign pos_bad  = (POSNS_CFG_W'(in_ch.position) >= cfg_i.positions_in_use) ||
                    (32'(in_ch.position) >= 32'(MAX_POSITIONS));
  assign pair_bad = (PAIRS_CFG_W'(in_ch.pair_index) >= cfg_i.pairs_in_use) ||
                    (32'(in_ch.pair_index) >= 32'(MAX_PAIRS));

  // Table values are the low 16 bits of the field (zero-filled if narrower)
  assign cos_raw = TABLE_W'($unsigned(in_ch.value_even));
  assign sin_raw = TABLE_W'($unsigned(in_ch.value_odd));

  assign addr_o = ADDR_W'(32'(in_ch.position) * 32'(MAX_PAIRS) + 32'(in_ch.pair_index));

  always_comb begin
    case (mode_e'(in_ch.mode))
      MODE_LOAD: op_sel = OP_LOAD;
      MODE_FWD:  op_sel = OP_FWD;
      MODE_INV:  op_sel = OP_INV;
      default:   op_sel = OP_NONE;
    endcase

    ctrl_o.op     = OP_NONE;
    ctrl_o.status = ST_OK;
    if (op_sel != OP_NONE) begin
      if (pos_bad) begin
        ctrl_o.status = ST_POS_RANGE;
      end else if (pair_bad) begin
        ctrl_o.status = ST_PAIR_RANGE;
      end else begin
        ctrl_o.op = op_sel;
      end
    end

    if (op_sel == OP_LOAD) begin
      a_o = VAL_W'(clamp_q14(cos_raw));
      b_o = VAL_W'(clamp_q14(sin_raw));
    end else begin
      a_o = VAL_W'(in_ch.value_even);
      b_o = VAL_W'(in_ch.value_odd);
    end
  end

endmodule

// File: src/rpr_back.sv
// Back end: cosine/sine table, four multipliers, round and saturate,
// output register. Depends on rpr_pkg and rpr_out_if.
module rpr_back #(
  parameter int MAX_POSITIONS = 512,
  parameter int MAX_PAIRS     = 64,
  parameter int DATA_WIDTH    = 16,
  parameter int ADDR_W        = 15,
  parameter int VAL_W         = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  rpr_pkg::ctrl_t          ctrl_i,
  input  logic [ADDR_W-1:0]       addr_i,
  input  logic signed [VAL_W-1:0] a_i,
  input  logic signed [VAL_W-1:0] b_i,
  output logic                    ready_o,
  rpr_out_if.source               out_ch
);
  import rpr_pkg::*;

  localparam int DEPTH = MAX_POSITIONS * MAX_PAIRS;
  localparam int DW    = DATA_WIDTH;
  localparam int PW    = DW + TABLE_W;     // one product
  localparam int SW    = PW + 2;           // sum of two plus rounding bias
  localparam int QW    = SW - ROUND_SHIFT; // after the shift

  // Table storage, undefined until loaded
  logic signed [TABLE_W-1:0] cos_mem [DEPTH];
  logic signed [TABLE_W-1:0] sin_mem [DEPTH];

  logic pop, en1, en2, en3;

  // Stage 1: table read data
  logic                      v1_q;
  ctrl_t                     ctrl1_q;
  logic signed [DW-1:0]      e1_q, o1_q;
  logic signed [TABLE_W-1:0] cos_rd_q, sin_rd_q;

  // Stage 2: products
  logic                 v2_q;
  ctrl_t                ctrl2_q;
  logic signed [PW-1:0] p_ec_q, p_os_q, p_es_q, p_oc_q;
  logic signed [PW-1:0] p_ec_d, p_os_d, p_es_d, p_oc_d;

  // Stage 3: result register
  logic                 out_v_q;
  logic signed [DW-1:0] out_e_q, out_e_d, out_o_q, out_o_d;
  status_e              status_q, status_d;

  assign en3     = !out_v_q || out_ch.ready;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign pop     = valid_i && en1;

  // {saturated, value} from a rounded, shifted sum
  function automatic logic [DW:0] sat_fn(input logic signed [QW-1:0] q);
    logic [DW:0] r;
    if ((&q[QW-1:DW-1]) || !(|q[QW-1:DW-1])) begin
      r = {1'b0, q[DW-1:0]};
    end else if (q[QW-1]) begin
      r = {1'b1, 1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (pop && (ctrl_i.op == OP_LOAD)) begin
      cos_mem[addr_i] <= a_i[TABLE_W-1:0];
      sin_mem[addr_i] <= b_i[TABLE_W-1:0];
    end
    if (pop) begin
      cos_rd_q <= cos_mem[addr_i];
      sin_rd_q <= sin_mem[addr_i];
    end
  end

  always_comb begin
    p_ec_d = e1_q * cos_rd_q;
    p_os_d = o1_q * sin_rd_q;
    p_es_d = e1_q * sin_rd_q;
    p_oc_d = o1_q * cos_rd_q;
  end

  always_comb begin
    logic signed [SW-1:0] e_sum, o_sum, e_t, o_t;
    logic [DW:0]          e_r, o_r;
    if (ctrl2_q.op == OP_INV) begin
      e_sum = SW'(p_ec_q) + SW'(p_os_q);
      o_sum = SW'(p_oc_q) - SW'(p_es_q);
    end else begin
      e_sum = SW'(p_ec_q) - SW'(p_os_q);
      o_sum = SW'(p_es_q) + SW'(p_oc_q);
    end
    e_t = e_sum + (SW'(1) << (ROUND_SHIFT - 1));
    o_t = o_sum + (SW'(1) << (ROUND_SHIFT - 1));
    e_r = sat_fn(QW'(e_t >>> ROUND_SHIFT));
    o_r = sat_fn(QW'(o_t >>> ROUND_SHIFT));
    if ((ctrl2_q.op == OP_FWD) || (ctrl2_q.op == OP_INV)) begin
      out_e_d  = e_r[DW-1:0];
      out_o_d  = o_r[DW-1:0];
      status_d = (e_r[DW] || o_r[DW]) ? ST_SAT : ST_OK;
    end else begin
      out_e_d  = '0;
      out_o_d  = '0;
      status_d = ctrl2_q.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) v1_q    <= valid_i;
      if (en2) v2_q    <= v1_q;
      if (en3) out_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ctrl1_q <= ctrl_i;
      e1_q    <= a_i[DW-1:0];
      o1_q    <= b_i[DW-1:0];
    end
    if (en2 && v1_q) begin
      ctrl2_q <= ctrl1_q;
      p_ec_q  <= p_ec_d;
      p_os_q  <= p_os_d;
      p_es_q  <= p_es_d;
      p_oc_q  <= p_oc_d;
    end
    if (en3 && v2_q) begin
      out_e_q  <= out_e_d;
      out_o_q  <= out_o_d;
      status_q <= status_d;
    end
  end

  assign out_ch.valid    = out_v_q;
  assign out_ch.out_even = out_e_q;
  assign out_ch.out_odd  = out_o_q;
  assign out_ch.status   = status_q;

endmodule

// File: src/rotary_pair_rotator_top.sv
// Top level of the rotary pair rotator: configuration registers, front end,
// queue and back end. Depends on rpr_pkg, rpr_if, rpr_front, rpr_queue, rpr_back.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      mode, position, pair_index, value_even, value_odd
//  out_ch   out  valid/ready      out_even, out_odd, status
//  cfg      in   cfg_we_i         cfg_index_i, cfg_data_i (write only)
//
// One item per cycle sustained while out_ch is ready; the single-port cosine/sine
// table takes one access (load write or rotation read) per cycle. A result passes
// through the queue, table read, product and result registers to out_ch.
// Reset clears the control state and sets the configuration registers to their
// defaults; the table is not cleared and must be loaded before use.
// A four-entry queue sits between front and back: input ready drops only when
// it is full, and the back pipeline holds in place while out_ch is stalled.
module rotary_pair_rotator_top #(
  parameter int MAX_POSITIONS = 512,
  parameter int MAX_PAIRS     = 64,
  parameter int DATA_WIDTH    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rpr_in_if.sink                            in_ch,
  rpr_out_if.source                         out_ch,
  input  logic                              cfg_we_i,
  input  logic [rpr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rpr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rpr_pkg::*;

  localparam int DEPTH   = MAX_POSITIONS * MAX_PAIRS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Queue value fields must hold both data elements and 16-bit table values
  localparam int VAL_W   = (DATA_WIDTH > TABLE_W) ? DATA_WIDTH : TABLE_W;
  localparam int ENTRY_W = $bits(ctrl_t) + ADDR_W + 2 * VAL_W;

  // Configuration registers
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PAIRS_IN_USE:     cfg_d.pairs_in_use     = cfg_data_i[PAIRS_CFG_W-1:0];
        REG_POSITIONS_IN_USE: cfg_d.positions_in_use = cfg_data_i[POSNS_CFG_W-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pairs_in_use     <= PAIRS_RESET;
      cfg_q.positions_in_use <= POSNS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end -> queue
  logic                    f_push, q_ready;
  ctrl_t                   f_ctrl;
  logic [ADDR_W-1:0]       f_addr;
  logic signed [VAL_W-1:0] f_a, f_b;
  logic [ENTRY_W-1:0]      q_in, q_out;

  // Queue -> back end
  logic                    q_valid, b_ready;
  ctrl_t                   b_ctrl;
  logic [ADDR_W-1:0]       b_addr;
  logic signed [VAL_W-1:0] b_a, b_b;

  rpr_front #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .MAX_PAIRS     (MAX_PAIRS),
    .DATA_WIDTH    (DATA_WIDTH),
    .ADDR_W        (ADDR_W),
    .VAL_W         (VAL_W)
  ) u_front (
    .in_ch         (in_ch),
    .cfg_i         (cfg_q),
    .queue_ready_i (q_ready),
    .push_o        (f_push),
    .ctrl_o        (f_ctrl),
    .addr_o        (f_addr),
    .a_o           (f_a),
    .b_o           (f_b)
  );

  assign q_in = {f_ctrl, f_addr, f_a, f_b};

  rpr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_in),
    .ready_o (q_ready),
    .pop_i   (b_ready),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {b_ctrl, b_addr, b_a, b_b} = q_out;

  rpr_back #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .MAX_PAIRS     (MAX_PAIRS),
    .DATA_WIDTH    (DATA_WIDTH),
    .ADDR_W        (ADDR_W),
    .VAL_W         (VAL_W)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ctrl_i  (b_ctrl),
    .addr_i  (b_addr),
    .a_i     (b_a),
    .b_i     (b_b),
    .ready_o (b_ready),
    .out_ch  (out_ch)
  );

endmodule

// File: tb/rpr_rotation_checker.sv
// Result checker for the rotary pair rotator: follows the item streams and
// the register port, predicts every result and compares it on arrival.
// Depends on rpr_pkg and the stream interfaces in rpr_if.
module rpr_rotation_checker
  import rpr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  rpr_in_if                      in_ch,
  rpr_out_if                     out_ch,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     mismatches_o,
  output int                     outstanding_o
);

  localparam int     TABLE_DEPTH  = 512 * 64;
  localparam int     REPORT_LIMIT = 10;
  localparam longint Q12_MAX      = 32767;
  localparam longint Q12_MIN      = -32768;
  localparam longint ROUND_HALF   = 8192;

  typedef struct packed {
    logic [TABLE_W-1:0] even_val;
    logic [TABLE_W-1:0] odd_val;
    status_e            status;
  } rotation_t;

  logic signed [TABLE_W-1:0] cos_q14 [TABLE_DEPTH];
  logic signed [TABLE_W-1:0] sin_q14 [TABLE_DEPTH];
  logic [PAIRS_CFG_W-1:0]    pairs_lim;
  logic [POSNS_CFG_W-1:0]    posns_lim;
  rotation_t                 expected_rotations [$];
  rotation_t                 want;
  rotation_t                 got;
  int                        mismatch_count = 0;
  int                        result_count = 0;

  // Q.26 sum -> Q.12, round half up, saturate
  function automatic logic signed [TABLE_W-1:0] to_q12(input longint prod_sum,
                                                        inout bit saturated);
    longint q;
    q = (prod_sum + ROUND_HALF) >>> ROUND_SHIFT;
    if (q > Q12_MAX) begin
      saturated = 1'b1;
      q = Q12_MAX;
    end else if (q < Q12_MIN) begin
      saturated = 1'b1;
      q = Q12_MIN;
    end
    return q[TABLE_W-1:0];
  endfunction

  function automatic logic signed [TABLE_W-1:0] clamp_unit(input logic signed [TABLE_W-1:0] v);
    if (v > Q14_ONE) begin
      return Q14_ONE;
    end else if (v < -Q14_ONE) begin
      return -Q14_ONE;
    end
    return v;
  endfunction

  // Result of one item; a load also updates the tables
  function automatic rotation_t rotate_or_load(input logic [MODE_W-1:0] mode,
                                               input logic [POS_W-1:0] pos,
                                               input logic [PAIR_W-1:0] pair,
                                               input logic signed [TABLE_W-1:0] ev,
                                               input logic signed [TABLE_W-1:0] od);
    rotation_t                  r;
    logic [POS_W+PAIR_W-1:0]    addr;
    longint                     e, o, c, s, sum_even, sum_odd;
    bit                         sat;
    r.even_val = '0;
    r.odd_val  = '0;
    r.status   = ST_OK;
    sat        = 1'b0;
    addr       = {pos, pair};
    e          = ev;
    o          = od;
    case (mode)
      MODE_LOAD, MODE_FWD, MODE_INV: begin
        if (pos >= posns_lim) begin
          r.status = ST_POS_RANGE;
        end else if (pair >= pairs_lim) begin
          r.status = ST_PAIR_RANGE;
        end else if (mode == MODE_LOAD) begin
          cos_q14[addr] = clamp_unit(ev);
          sin_q14[addr] = clamp_unit(od);
        end else begin
          c = cos_q14[addr];
          s = sin_q14[addr];
          if (mode == MODE_FWD) begin
            sum_even = e * c - o * s;
            sum_odd  = e * s + o * c;
          end else begin
            sum_even = e * c + o * s;
            sum_odd  = o * c - e * s;
          end
          r.even_val = to_q12(sum_even, sat);
          r.odd_val  = to_q12(sum_odd, sat);
          if (sat) begin
            r.status = ST_SAT;
          end
        end
      end
      default: ;  // spare mode code: ignored, zero result
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_lim     <= PAIRS_RESET;
      posns_lim     <= POSNS_RESET;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // results first: nothing accepted on this edge can already be out
      if (out_ch.valid && out_ch.ready) begin
        got.even_val = out_ch.out_even;
        got.odd_val  = out_ch.out_odd;
        got.status   = status_e'(out_ch.status);
        if (expected_rotations.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("result %0d with nothing pending: even %0d odd %0d status %0d",
                     result_count, $signed(got.even_val), $signed(got.odd_val), got.status);
          end
          mismatch_count++;
        end else begin
          want = expected_rotations.pop_front();
          if (got.even_val !== want.even_val || got.odd_val !== want.odd_val ||
              got.status !== want.status) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("result %0d: expected even %0d odd %0d status %0d, got even %0d odd %0d status %0d",
                       result_count, $signed(want.even_val), $signed(want.odd_val), want.status,
                       $signed(got.even_val), $signed(got.odd_val), got.status);
            end
            mismatch_count++;
          end
        end
        result_count++;
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_rotations.push_back(rotate_or_load(in_ch.mode, in_ch.position,
                                                    in_ch.pair_index, in_ch.value_even,
                                                    in_ch.value_odd));
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_PAIRS_IN_USE:     pairs_lim <= cfg_data_i[PAIRS_CFG_W-1:0];
          REG_POSITIONS_IN_USE: posns_lim <= cfg_data_i[POSNS_CFG_W-1:0];
          default: ;
        endcase
      end
      mismatches_o  <= mismatch_count;
      outstanding_o <= expected_rotations.size();
    end
  end

endmodule

// File: tb/rotary_pair_rotator_top_test.sv
// Testbench top for the rotary pair rotator: clock, reset, item stimulus,
// result back-pressure and the verdict. Depends on rpr_pkg, rpr_if,
// rotary_pair_rotator_top and rpr_rotation_checker.
module rotary_pair_rotator_top_test;
  import rpr_pkg::*;

  localparam int              DATA_W        = 16;
  localparam int              PAIR_SLOTS    = 64;
  localparam int              POS_SLOTS     = 512;
  // the one mode code the package leaves unnamed; the block ignores it
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
  localparam int              RANDOM_ITEMS  = 850;
  localparam int              PHASE_COUNT   = 6;
  localparam int              LONG_HOLD     = 80;    // cycles, well past queue + pipe depth
  localparam int              DRAIN_LIMIT   = 5000;
  localparam int              SETTLE_CYCLES = 6;     // cycles waited after the last result is back

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  rpr_in_if  #(.DATA_WIDTH(DATA_W)) in_ch ();
  rpr_out_if #(.DATA_WIDTH(DATA_W)) out_ch ();

  int mismatches;
  int outstanding;

  // calm: last phase, no idling on either side
  // hold_req: asks the result side for one long hold-off
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  // our view of the limits and of which table entries hold data; a rotation
  // that passes the range checks is only ever sent to a loaded entry
  int pairs_now = PAIR_SLOTS;
  int posns_now = POS_SLOTS;
  bit entry_loaded [PAIR_SLOTS*POS_SLOTS];
  int loaded_addrs [$];

  rotary_pair_rotator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  rpr_rotation_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // Offer one item and hold it until accepted, then maybe idle a burst.
  // valid stays high from one item to the next, so it is only ever
  // assigned once per edge.
  task automatic send(input logic [MODE_W-1:0] mode, input int pos, input int pair,
                      input logic signed [DATA_W-1:0] ev, input logic signed [DATA_W-1:0] od);
    int addr;
    addr = pos * PAIR_SLOTS + pair;
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.position   <= pos[POS_W-1:0];
    in_ch.pair_index <= pair[PAIR_W-1:0];
    in_ch.value_even <= ev;
    in_ch.value_odd  <= od;
    // loads outside the limits are dropped by the block
    if (mode == MODE_LOAD && pos < posns_now && pair < pairs_now && !entry_loaded[addr]) begin
      entry_loaded[addr] = 1'b1;
      loaded_addrs.push_back(addr);
    end
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every result is back. The extra edge
  // lets the checker count an item accepted on the last edge.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // registers only change with the block drained
  task automatic set_limits(input int pairs, input int posns);
    settle();
    write_reg(REG_PAIRS_IN_USE, pairs);
    write_reg(REG_POSITIONS_IN_USE, posns);
    pairs_now = pairs;
    posns_now = posns;
  endtask

  // cosine/sine to load: mostly within +-1, sometimes any value to hit the clamp
  function automatic logic signed [DATA_W-1:0] trig_value();
    case ($urandom_range(0, 5))
      0:       return DATA_W'($urandom);
      1:       return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
      default: return DATA_W'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // element to rotate: full range drives saturation, small values rounding
  function automatic logic signed [DATA_W-1:0] element_value();
    case ($urandom_range(0, 5))
      0:       return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      1, 2:    return DATA_W'($urandom);
      default: return DATA_W'(int'($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  // in-range entry; half the time from a small corner so entries get reused
  task automatic pick_target(output int pos, output int pair);
    if ($urandom_range(0, 1) != 0) begin
      pos  = $urandom_range(0, ((posns_now < 8) ? posns_now : 8) - 1);
      pair = $urandom_range(0, ((pairs_now < 4) ? pairs_now : 4) - 1);
    end else begin
      pos  = $urandom_range(0, posns_now - 1);
      pair = $urandom_range(0, pairs_now - 1);
    end
  endtask

  // Mix: spare mode, out-of-range items (when the limits allow any), loads,
  // and rotations of loaded entries. A rotation that lands on an empty entry
  // becomes a load of that entry instead.
  task automatic random_item();
    int                roll;
    int                pos;
    int                pair;
    int                addr;
    bit                found;
    logic [MODE_W-1:0] rot_mode;
    roll     = $urandom_range(0, 99);
    rot_mode = ($urandom_range(0, 1) != 0) ? MODE_FWD : MODE_INV;
    found    = 1'b0;
    if (roll < 5) begin
      send(MODE_SPARE, $urandom_range(0, POS_SLOTS - 1), $urandom_range(0, PAIR_SLOTS - 1),
           DATA_W'($urandom), DATA_W'($urandom));
    end else if (roll < 15 && (pairs_now < PAIR_SLOTS || posns_now < POS_SLOTS)) begin
      if (posns_now < POS_SLOTS && (pairs_now == PAIR_SLOTS || $urandom_range(0, 1) != 0)) begin
        pos  = $urandom_range(posns_now, POS_SLOTS - 1);
        pair = $urandom_range(0, PAIR_SLOTS - 1);
      end else begin
        pos  = $urandom_range(0, POS_SLOTS - 1);
        pair = $urandom_range(pairs_now, PAIR_SLOTS - 1);
      end
      send(($urandom_range(0, 2) == 0) ? MODE_LOAD : rot_mode, pos, pair,
           element_value(), element_value());
    end else if (roll < 35) begin
      pick_target(pos, pair);
      send(MODE_LOAD, pos, pair, trig_value(), trig_value());
    end else begin
      for (int tries = 0; tries < 4 && !found && loaded_addrs.size() > 0; tries++) begin
        addr  = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
        pos   = addr / PAIR_SLOTS;
        pair  = addr % PAIR_SLOTS;
        found = (pos < posns_now) && (pair < pairs_now);
      end
      if (!found) begin
        pick_target(pos, pair);
      end
      if (entry_loaded[pos * PAIR_SLOTS + pair]) begin
        send(rot_mode, pos, pair, element_value(), element_value());
      end else begin
        send(MODE_LOAD, pos, pair, trig_value(), trig_value());
      end
    end
  endtask

  // Result side: random stall bursts, one long hold-off on request so the
  // queue fills and input ready drops, always ready in the calm phase.
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int waited;
    int items_per_phase;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_LOAD;
    in_ch.position   <= '0;
    in_ch.pair_index <= '0;
    in_ch.value_even <= '0;
    in_ch.value_odd  <= '0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= REG_PAIRS_IN_USE;
    cfg_data_i       <= '0;
    rst_ni           <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, reset limits (64 pairs, 512 positions) ----
    send(MODE_LOAD, 0, 0, 16384, 0);             // identity
    send(MODE_LOAD, 511, 63, 32767, -32768);     // both clamp to +-1, far corner
    send(MODE_LOAD, 1, 1, 11585, 11585);         // 45 degrees
    send(MODE_LOAD, 2, 2, -16384, 16384);
    send(MODE_LOAD, 3, 3, 8192, -8192);          // exact halves for rounding
    send(MODE_FWD, 0, 0, 32767, -32768);         // identity keeps the extremes
    send(MODE_INV, 0, 0, -32768, 0);
    send(MODE_FWD, 511, 63, 32767, 32767);       // saturates high
    send(MODE_INV, 511, 63, -32768, 32767);      // even side saturates low
    send(MODE_FWD, 1, 1, 32767, 32767);          // odd side overflows
    send(MODE_INV, 1, 1, 1, 0);
    send(MODE_FWD, 2, 2, -32768, -32768);
    send(MODE_FWD, 3, 3, 1, 0);                  // +half rounds up
    send(MODE_FWD, 3, 3, -1, 0);                 // -half rounds up to zero
    send(MODE_SPARE, 511, 63, 32767, -32768);    // ignored
    send(MODE_SPARE, 0, 0, -32768, 32767);

    // smallest limits: only position 0, pair 0 is usable
    set_limits(1, 1);
    send(MODE_FWD, 1, 0, 1000, 2000);            // position out of range
    send(MODE_INV, 0, 1, 1000, 2000);            // pair out of range
    send(MODE_FWD, 1, 1, 1000, 2000);            // both out: position wins
    send(MODE_LOAD, 5, 5, 16384, 16384);         // dropped load
    send(MODE_LOAD, 0, 3, -16384, 0);            // dropped load
    send(MODE_INV, 0, 0, 12345, -12345);         // still the identity entry
    send(MODE_SPARE, 300, 40, 1, 1);

    // ---- random part over several limit settings ----
    items_per_phase = RANDOM_ITEMS / PHASE_COUNT;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: set_limits(PAIR_SLOTS, POS_SLOTS);
        1: set_limits(1, POS_SLOTS);
        2: set_limits(PAIR_SLOTS, 1);
        PHASE_COUNT - 1: begin
          set_limits(PAIR_SLOTS, POS_SLOTS);
          calm <= 1'b1;
        end
        default: set_limits($urandom_range(1, PAIR_SLOTS), $urandom_range(1, POS_SLOTS));
      endcase
      for (int n = 0; n < items_per_phase; n++) begin
        if (phase == 0 && n == 40) begin
          hold_req <= 1'b1;
        end
        random_item();
      end
    end

    // ---- drain and verdict ----
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    // a few more edges so a stray extra result would still be caught
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
